// ----- hdl/cts_pkg.sv -----
// shared types and constants for the cooperative task scheduler
// item structs, opcode and result kind codes, controller command and status groups
// no dependencies
`timescale 1ns / 1ps

package cts_pkg;

	// most run results one dispatch may give
	localparam int MAX_RUNS  = 16;
	localparam int RUN_IDX_W = 4;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_DELETE   = 2'd1,
		OP_TICK     = 2'd2,
		OP_DISPATCH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_DELETED   = 3'd2,
		KIND_TICK_DONE = 3'd3,
		KIND_RUN       = 3'd4,
		KIND_NONE      = 3'd5
	} kind_t;

	typedef struct packed {
		op_t         opcode;
		logic [15:0] task_handle;
		logic [31:0] start_delay;
		logic [31:0] period;
		logic [3:0]  slot;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  slot_res;
		logic [15:0] task_handle_res;
		logic        last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic idx_inc;
		logic add_wr;
		logic tick_wr;
		logic disp_wr;
		logic fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic idx_end;
		logic cur_valid;
		logic pend_nz;
		logic out_free;
		logic hold_valid;
		logic run_last;
	} status_t;

endpackage

// ----- hdl/cts_dpath.sv -----
// scheduler datapath: slot table memories, valid bits, scan index, result hold and output register
// depends on cts_pkg
`timescale 1ns / 1ps

module cts_dpath #(
	parameter int SLOTS           = 16,
	parameter int RUN_COUNT_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cts_pkg::in_item_t  in_item,
	input  cts_pkg::cmd_t      cmd,
	output cts_pkg::status_t   status,
	output logic               out_valid,
	input  logic               out_ready,
	output cts_pkg::out_item_t out_item
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = ((IW + 1) > 5) ? (IW + 1) : 5;
	localparam int RW = RUN_COUNT_WIDTH;

	logic [IW:0]    idx_q;
	logic [IW-1:0]  cur_idx;
	logic [SLOTS-1:0] valid_q;

	logic [15:0] add_handle_q;
	logic [31:0] add_delay_q;
	logic [31:0] add_period_q;

	logic [15:0]   handle_mem [SLOTS];
	logic [31:0]   delay_mem  [SLOTS];
	logic [31:0]   period_mem [SLOTS];
	logic [RW-1:0] pend_mem   [SLOTS];

	logic [15:0]   handle_rd_q;
	logic [31:0]   delay_rd_q;
	logic [31:0]   period_rd_q;
	logic [RW-1:0] pend_rd_q;

	logic               hold_valid_q;
	cts_pkg::out_item_t hold_q;
	logic               out_valid_q;
	cts_pkg::out_item_t out_q;
	logic [cts_pkg::RUN_IDX_W-1:0] run_cnt_q;

	logic [CW-1:0] del_ext;
	logic [IW-1:0] del_idx;
	logic          del_in_range;
	logic          out_free;
	logic          delay_zero;
	logic [31:0]   tick_delay;
	logic [RW-1:0] tick_pend;
	cts_pkg::out_item_t hold_init;

	assign cur_idx      = idx_q[IW-1:0];
	assign del_ext      = CW'(in_item.slot);
	assign del_idx      = del_ext[IW-1:0];
	assign del_in_range = del_ext < CW'(SLOTS);
	assign out_free     = !out_valid_q || out_ready;

	// tick update of one slot
	always_comb begin
		delay_zero = delay_rd_q == 32'd0;
		if (!delay_zero) begin
			tick_delay = delay_rd_q - 32'd1;
		end else if (period_rd_q != 32'd0) begin
			tick_delay = period_rd_q - 32'd1;
		end else begin
			tick_delay = delay_rd_q;
		end
		if (delay_zero && !(&pend_rd_q)) begin
			tick_pend = pend_rd_q + 1'b1;
		end else begin
			tick_pend = pend_rd_q;
		end
	end

	// first hold contents for each opcode
	always_comb begin
		hold_init = '{kind: cts_pkg::KIND_TICK_DONE, slot_res: 4'd0,
			task_handle_res: 16'd0, last: 1'b1};
		unique case (in_item.opcode)
			cts_pkg::OP_ADD:      hold_init.kind = cts_pkg::KIND_FULL;
			cts_pkg::OP_DELETE: begin
				hold_init.kind     = cts_pkg::KIND_DELETED;
				hold_init.slot_res = in_item.slot;
			end
			cts_pkg::OP_TICK:     hold_init.kind = cts_pkg::KIND_TICK_DONE;
			cts_pkg::OP_DISPATCH: hold_init.kind = cts_pkg::KIND_NONE;
			default:              hold_init.kind = cts_pkg::KIND_NONE;
		endcase
	end

	// slot table memories, one write and one registered read at the scan index
	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			handle_mem[cur_idx] <= add_handle_q;
			delay_mem[cur_idx]  <= add_delay_q;
			period_mem[cur_idx] <= add_period_q;
			pend_mem[cur_idx]   <= '0;
		end
		if (cmd.tick_wr) begin
			delay_mem[cur_idx] <= tick_delay;
			pend_mem[cur_idx]  <= tick_pend;
		end
		if (cmd.disp_wr) begin
			pend_mem[cur_idx] <= pend_rd_q - 1'b1;
		end
		handle_rd_q <= handle_mem[cur_idx];
		delay_rd_q  <= delay_mem[cur_idx];
		period_rd_q <= period_mem[cur_idx];
		pend_rd_q   <= pend_mem[cur_idx];
	end

	// add fields latched on input transfer
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			add_handle_q <= in_item.task_handle;
			add_delay_q  <= in_item.start_delay;
			add_period_q <= in_item.period;
		end
	end

	// scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.start) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.start && in_item.opcode == cts_pkg::OP_DELETE && del_in_range) begin
				valid_q[del_idx] <= 1'b0;
			end
			if (cmd.add_wr) begin
				valid_q[cur_idx] <= 1'b1;
			end
			if (cmd.disp_wr && period_rd_q == 32'd0) begin
				valid_q[cur_idx] <= 1'b0;
			end
		end
	end

	// held result and run count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			run_cnt_q    <= '0;
		end else if (cmd.start) begin
			hold_valid_q <= in_item.opcode != cts_pkg::OP_DISPATCH;
			run_cnt_q    <= '0;
		end else if (cmd.disp_wr) begin
			hold_valid_q <= 1'b1;
			run_cnt_q    <= run_cnt_q + 1'b1;
		end else if (cmd.fin) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hold_q <= hold_init;
		end else if (cmd.add_wr) begin
			hold_q <= '{kind: cts_pkg::KIND_ADDED, slot_res: 4'(idx_q),
				task_handle_res: 16'd0, last: 1'b1};
		end else if (cmd.disp_wr) begin
			hold_q <= '{kind: cts_pkg::KIND_RUN, slot_res: 4'(idx_q),
				task_handle_res: handle_rd_q, last: 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin || (cmd.disp_wr && hold_valid_q)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (hold_valid_q) begin
				out_q      <= hold_q;
				out_q.last <= 1'b1;
			end else begin
				out_q <= '{kind: cts_pkg::KIND_NONE, slot_res: 4'd0,
					task_handle_res: 16'd0, last: 1'b1};
			end
		end else if (cmd.disp_wr && hold_valid_q) begin
			out_q      <= hold_q;
			out_q.last <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign status.idx_end    = idx_q == (IW + 1)'(SLOTS);
	assign status.cur_valid  = valid_q[cur_idx];
	assign status.pend_nz    = pend_rd_q != '0;
	assign status.out_free   = out_free;
	assign status.hold_valid = hold_valid_q;
	assign status.run_last   = run_cnt_q == cts_pkg::RUN_IDX_W'(cts_pkg::MAX_RUNS - 1);

endmodule

// ----- hdl/cts_ctrl.sv -----
// scheduler controller: sequences add search, tick and dispatch scans and result delivery
// depends on cts_pkg
`timescale 1ns / 1ps

module cts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cts_pkg::op_t     opcode,
	input  cts_pkg::status_t status,
	output cts_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ADD  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_EX   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t       state_q, state_d;
	cts_pkg::op_t op_q;

	// opcode of the item in work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= cts_pkg::OP_ADD;
		end else if (in_valid && state_q == ST_IDLE) begin
			op_q <= opcode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (opcode == cts_pkg::OP_ADD) begin
						state_d = ST_ADD;
					end else if (opcode == cts_pkg::OP_DELETE) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_ADD: begin
				if (status.idx_end) begin
					state_d = ST_FIN;
				end else if (!status.cur_valid) begin
					cmd.add_wr = 1'b1;
					state_d    = ST_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_RD: begin
				if (status.idx_end) begin
					state_d = ST_FIN;
				end else if (!status.cur_valid) begin
					cmd.idx_inc = 1'b1;
				end else begin
					state_d = ST_EX;
				end
			end
			ST_EX: begin
				if (op_q == cts_pkg::OP_TICK) begin
					cmd.tick_wr = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = ST_RD;
				end else if (!status.pend_nz) begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_RD;
				end else if (!status.hold_valid || status.out_free) begin
					// any held run goes out, this slot's run takes its place
					cmd.disp_wr = 1'b1;
					if (status.run_last) begin
						state_d = ST_FIN;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_RD;
					end
				end
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/cooperative_task_scheduler_core.sv -----
// Sequencing: a delete clears its slot's valid bit, if in range, at input transfer and finishes;
// an add scans from slot 0 up to the first free slot; tick and dispatch scan all slots,
// one slot per memory read, with a read step and an execute step for each valid slot;
// a dispatch that reaches 16 runs ends its scan there.
// Throughput: one item at a time; the slot scan through the single table read port sets it.
// Dispatch results leave one per transfer, stalls on out_ready hold the scan.
// Reset: arst_n clears controller, valid bits and output register at once; the slot
// memories are not cleared, so no clearing pass follows reset.
`timescale 1ns / 1ps

module cooperative_task_scheduler_core #(
	parameter int SLOTS           = 16,
	parameter int RUN_COUNT_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cts_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cts_pkg::out_item_t out_item
);

	cts_pkg::cmd_t    cmd;
	cts_pkg::status_t status;

	// control sequencer
	cts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (in_item.opcode),
		.status   (status),
		.cmd      (cmd)
	);

	// slot table and result registers
	cts_dpath #(
		.SLOTS           (SLOTS),
		.RUN_COUNT_WIDTH (RUN_COUNT_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- hdl/cts_checker.sv -----
// port-level checks for the cooperative task scheduler, bound to the top level
// depends on cts_pkg and cooperative_task_scheduler_core
`timescale 1ns / 1ps

module cts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input cts_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input cts_pkg::out_item_t out_item
);

	// waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("waiting input changed");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// one item in work at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// only run results may be non-final
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind != cts_pkg::KIND_RUN |-> out_item.last)
		else $error("single result without last");

	// tick and nothing-ready results carry no slot or handle
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.kind == cts_pkg::KIND_TICK_DONE ||
			out_item.kind == cts_pkg::KIND_NONE)
		|-> out_item.slot_res == 4'd0 && out_item.task_handle_res == 16'd0)
		else $error("stray slot or handle");

endmodule

bind cooperative_task_scheduler_core cts_checker u_cts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
